// File: rtl/obj_vertex_face_line_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// OBJ vertex/face line parser assertion macros
// Concurrent assertion helpers for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef OBJ_VERTEX_FACE_LINE_PARSER_UNIT_DEFINES_SVH
`define OBJ_VERTEX_FACE_LINE_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OVFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ovfp same-cycle check failed");
`define OVFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ovfp next-cycle check failed");
`else
`define OVFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define OVFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ovfp_pkg.sv
// ----------------------------------------------------------------------------
// OBJ vertex/face line parser package
// Character codes, record kinds, parser state types and the result struct.
// ----------------------------------------------------------------------------
package ovfp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int TOTAL_WIDTH = 24;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_F       = 8'h66;
   localparam logic [7:0] CHAR_V       = 8'h76;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_VERTEX = 2'd1;
   localparam logic [1:0] KIND_FACE   = 2'd2;

   typedef enum logic [2:0] {
      LP_START,
      LP_SAW_V,
      LP_SAW_F,
      LP_VERTEX,
      LP_FACE,
      LP_SKIP
   } line_phase_type;

   typedef enum logic [2:0] {
      FP_LEAD,
      FP_INT,
      FP_FRAC1,
      FP_FRACR,
      FP_TAIL
   } field_phase_type;

   typedef struct packed {
      logic [1:0]             record_kind;
      logic [VALUE_WIDTH-1:0] first_value;
      logic [VALUE_WIDTH-1:0] second_value;
      logic [VALUE_WIDTH-1:0] third_value;
      logic                   end_of_text;
      logic [TOTAL_WIDTH-1:0] vertex_total;
      logic [TOTAL_WIDTH-1:0] face_total;
   } record_type;

   typedef struct packed {
      logic       emit;
      record_type record;
   } parse_result_type;

endpackage

// File: rtl/ovfp_field_value.sv
// ----------------------------------------------------------------------------
// OBJ parser field value
// Converts the accumulated field into a coordinate in hundredths or an index.
// ----------------------------------------------------------------------------
module ovfp_field_value #(
   parameter int COORD_WIDTH = 32
) (
   input  logic [COORD_WIDTH-2:0]           acc_value,
   input  logic [3:0]                       frac_digit,
   input  logic                             negative,
   input  logic                             vertex,
   output logic [ovfp_pkg::VALUE_WIDTH-1:0] field_value
);
   import ovfp_pkg::*;

   localparam int AW = COORD_WIDTH - 1;
   localparam int SW = AW + 7;
   localparam int EW = (COORD_WIDTH > VALUE_WIDTH) ? COORD_WIDTH : VALUE_WIDTH;

   logic [6:0]    frac_x10;
   logic [SW-1:0] scaled;
   logic          saturate;
   logic [AW-1:0] magnitude;
   logic [EW-1:0] extended;
   logic [EW-1:0] signed_value;

   always_comb begin
      frac_x10     = {frac_digit, 3'b000} + {2'b00, frac_digit, 1'b0};
      scaled       = (SW'(acc_value) << 6) + (SW'(acc_value) << 5)
                   + (SW'(acc_value) << 2) + SW'(frac_x10);
      saturate     = |scaled[SW-1:AW];
      magnitude    = saturate ? {AW{1'b1}} : scaled[AW-1:0];
      extended     = EW'(magnitude);
      signed_value = negative ? (~extended + EW'(1)) : extended;
      if (vertex) begin
         field_value = signed_value[VALUE_WIDTH-1:0];
      end else begin
         field_value = VALUE_WIDTH'(acc_value);
      end
   end

endmodule

// File: rtl/ovfp_line_parser.sv
// ----------------------------------------------------------------------------
// OBJ parser line state machine
// Holds the line and field state and forms one record per finished line and per zero byte.
// ----------------------------------------------------------------------------
module ovfp_line_parser #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [7:0]                 text_byte,
   output ovfp_pkg::parse_result_type result
);
   import ovfp_pkg::*;

   localparam int AW = COORD_WIDTH - 1;
   localparam int DW = AW + 4;

   line_phase_type         line_phase_ff, line_phase_in;
   field_phase_type        field_phase_ff, field_phase_in;
   logic [1:0]             field_number_ff, field_number_in;
   logic                   negative_ff, negative_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic [3:0]             frac_ff, frac_in;
   logic [VALUE_WIDTH-1:0] done_first_ff, done_first_in;
   logic [VALUE_WIDTH-1:0] done_second_ff, done_second_in;
   logic [COUNT_WIDTH-1:0] vertex_count_ff, vertex_count_in;
   logic [COUNT_WIDTH-1:0] face_count_ff, face_count_in;

   logic                   is_eot;
   logic                   is_newline;
   logic                   is_space;
   logic                   is_digit;
   logic                   in_vertex;
   logic                   line_end;
   logic                   vertex_bump;
   logic                   face_bump;
   logic [COUNT_WIDTH-1:0] vertex_next;
   logic [COUNT_WIDTH-1:0] face_next;
   logic [DW-1:0]          digit_prod;
   logic [AW-1:0]          acc_digit;
   logic [VALUE_WIDTH-1:0] cur_value;
   logic                   end_field;

   assign is_eot      = (text_byte == CHAR_NUL);
   assign is_newline  = (text_byte == CHAR_NEWLINE);
   assign is_space    = (text_byte == CHAR_SPACE);
   assign is_digit    = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign in_vertex   = (line_phase_ff == LP_VERTEX);
   assign line_end    = ((line_phase_ff == LP_VERTEX) || (line_phase_ff == LP_FACE))
                        && (is_newline || is_eot);
   assign vertex_bump = line_end && in_vertex && !(&vertex_count_ff);
   assign face_bump   = line_end && !in_vertex && !(&face_count_ff);
   assign vertex_next = vertex_count_ff + COUNT_WIDTH'(vertex_bump);
   assign face_next   = face_count_ff + COUNT_WIDTH'(face_bump);

   assign digit_prod  = (DW'(acc_ff) << 3) + (DW'(acc_ff) << 1) + DW'(text_byte[3:0]);
   assign acc_digit   = (|digit_prod[DW-1:AW]) ? {AW{1'b1}} : digit_prod[AW-1:0];

   ovfp_field_value #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_field_value (
      .acc_value  (acc_ff),
      .frac_digit (frac_ff),
      .negative   (negative_ff),
      .vertex     (in_vertex),
      .field_value(cur_value)
   );

   always_comb begin
      line_phase_in   = line_phase_ff;
      field_phase_in  = field_phase_ff;
      field_number_in = field_number_ff;
      negative_in     = negative_ff;
      acc_in          = acc_ff;
      frac_in         = frac_ff;
      done_first_in   = done_first_ff;
      done_second_in  = done_second_ff;
      vertex_count_in = vertex_next;
      face_count_in   = face_next;
      end_field       = 1'b0;

      unique case (line_phase_ff)
         LP_START: begin
            if (text_byte == CHAR_V) begin
               line_phase_in = LP_SAW_V;
            end else if (text_byte == CHAR_F) begin
               line_phase_in = LP_SAW_F;
            end else if (!is_newline && !is_eot) begin
               line_phase_in = LP_SKIP;
            end
         end
         LP_SAW_V, LP_SAW_F: begin
            if (is_space) begin
               line_phase_in   = (line_phase_ff == LP_SAW_V) ? LP_VERTEX : LP_FACE;
               field_number_in = 2'd0;
               field_phase_in  = FP_LEAD;
               negative_in     = 1'b0;
               acc_in          = '0;
               frac_in         = '0;
               done_first_in   = '0;
               done_second_in  = '0;
            end else if (is_newline) begin
               line_phase_in = LP_START;
            end else if (!is_eot) begin
               line_phase_in = LP_SKIP;
            end
         end
         LP_VERTEX, LP_FACE: begin
            if (line_end) begin
               line_phase_in   = LP_START;
               field_number_in = 2'd0;
               field_phase_in  = FP_LEAD;
               negative_in     = 1'b0;
               acc_in          = '0;
               frac_in         = '0;
            end else if (field_number_ff != 2'd3) begin
               unique case (field_phase_ff)
                  FP_LEAD: begin
                     priority if (is_space || (text_byte == CHAR_TAB)) begin
                        field_phase_in = FP_LEAD;
                     end else if (in_vertex && (text_byte == CHAR_MINUS)) begin
                        negative_in    = 1'b1;
                        field_phase_in = FP_INT;
                     end else if (is_digit) begin
                        acc_in         = acc_digit;
                        field_phase_in = FP_INT;
                     end else if (in_vertex && (text_byte == CHAR_DOT)) begin
                        field_phase_in = FP_FRAC1;
                     end else begin
                        field_phase_in = FP_TAIL;
                     end
                  end
                  FP_INT: begin
                     priority if (is_digit) begin
                        acc_in = acc_digit;
                     end else if (in_vertex && (text_byte == CHAR_DOT)) begin
                        field_phase_in = FP_FRAC1;
                     end else if (is_space) begin
                        end_field = 1'b1;
                     end else begin
                        field_phase_in = FP_TAIL;
                     end
                  end
                  FP_FRAC1: begin
                     priority if (is_digit) begin
                        frac_in        = text_byte[3:0];
                        field_phase_in = FP_FRACR;
                     end else if (is_space) begin
                        end_field = 1'b1;
                     end else begin
                        field_phase_in = FP_TAIL;
                     end
                  end
                  FP_FRACR: begin
                     priority if (is_digit) begin
                        field_phase_in = FP_FRACR;
                     end else if (is_space) begin
                        end_field = 1'b1;
                     end else begin
                        field_phase_in = FP_TAIL;
                     end
                  end
                  default: begin
                     end_field = is_space;
                  end
               endcase
            end
         end
         default: begin
            if (is_newline) begin
               line_phase_in = LP_START;
            end
         end
      endcase

      if (end_field) begin
         priority if (field_number_ff == 2'd0) begin
            done_first_in   = cur_value;
            field_number_in = 2'd1;
            field_phase_in  = FP_LEAD;
            negative_in     = 1'b0;
            acc_in          = '0;
            frac_in         = '0;
         end else if (field_number_ff == 2'd1) begin
            done_second_in  = cur_value;
            field_number_in = 2'd2;
            field_phase_in  = FP_LEAD;
            negative_in     = 1'b0;
            acc_in          = '0;
            frac_in         = '0;
         end else begin
            field_number_in = 2'd3;
         end
      end

      if (is_eot) begin
         line_phase_in   = LP_START;
         field_phase_in  = FP_LEAD;
         field_number_in = 2'd0;
         negative_in     = 1'b0;
         acc_in          = '0;
         frac_in         = '0;
         done_first_in   = '0;
         done_second_in  = '0;
         vertex_count_in = '0;
         face_count_in   = '0;
      end
   end

   always_comb begin
      result                     = '0;
      result.emit                = is_eot || line_end;
      result.record.end_of_text  = is_eot;
      result.record.vertex_total = TOTAL_WIDTH'(vertex_next);
      result.record.face_total   = TOTAL_WIDTH'(face_next);
      if (line_end) begin
         result.record.record_kind = in_vertex ? KIND_VERTEX : KIND_FACE;
         priority if (field_number_ff == 2'd0) begin
            result.record.first_value = cur_value;
         end else if (field_number_ff == 2'd1) begin
            result.record.first_value  = done_first_ff;
            result.record.second_value = cur_value;
         end else begin
            result.record.first_value  = done_first_ff;
            result.record.second_value = done_second_ff;
            result.record.third_value  = cur_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_phase_ff   <= LP_START;
         field_phase_ff  <= FP_LEAD;
         field_number_ff <= 2'd0;
         negative_ff     <= 1'b0;
         acc_ff          <= '0;
         frac_ff         <= '0;
         done_first_ff   <= '0;
         done_second_ff  <= '0;
         vertex_count_ff <= '0;
         face_count_ff   <= '0;
      end else if (advance) begin
         line_phase_ff   <= line_phase_in;
         field_phase_ff  <= field_phase_in;
         field_number_ff <= field_number_in;
         negative_ff     <= negative_in;
         acc_ff          <= acc_in;
         frac_ff         <= frac_in;
         done_first_ff   <= done_first_in;
         done_second_ff  <= done_second_in;
         vertex_count_ff <= vertex_count_in;
         face_count_ff   <= face_count_in;
      end
   end

endmodule

// File: rtl/obj_vertex_face_line_parser_unit.sv
// ----------------------------------------------------------------------------
// OBJ vertex/face line parser
// Streams OBJ text one byte per request and returns vertex and face records.
// ----------------------------------------------------------------------------
// The req channel carries one text byte per request; a zero byte ends the
// text. The rsp channel carries one record for each byte that finishes a
// "v " or "f " line and for every zero byte, with the running vertex and
// face totals. Bytes that finish nothing produce no response.
// A byte is taken into an input register, parsed by the line state machine,
// and its record lands in the output register, from which the response is
// driven. Bytes are taken at one byte per cycle while req_stall is low; the
// digit accumulator and line state update once for each byte parsed.
// While rsp_stall holds a waiting record, bytes that produce no record keep
// flowing; the next byte that would produce a record waits in the input
// register and req_stall rises.
// Synchronous reset empties both registers and returns the parser to the
// start of a new text with zero totals; a zero byte returns the parser there
// too after its record is formed.
// ----------------------------------------------------------------------------
`include "obj_vertex_face_line_parser_unit_defines.svh"

module obj_vertex_face_line_parser_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_text_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [1:0]                              rsp_record_kind,
   output logic signed [ovfp_pkg::VALUE_WIDTH-1:0] rsp_first_value,
   output logic signed [ovfp_pkg::VALUE_WIDTH-1:0] rsp_second_value,
   output logic signed [ovfp_pkg::VALUE_WIDTH-1:0] rsp_third_value,
   output logic                                    rsp_end_of_text,
   output logic [ovfp_pkg::TOTAL_WIDTH-1:0]        rsp_vertex_total,
   output logic [ovfp_pkg::TOTAL_WIDTH-1:0]        rsp_face_total
);
   import ovfp_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff;
   record_type       out_record_ff;
   parse_result_type parse;
   logic             advance;
   logic             req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall || !parse.emit);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ovfp_line_parser #(
      .COORD_WIDTH(COORD_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_line_parser (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .text_byte(in_byte_ff),
      .result   (parse)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && parse.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && parse.emit) begin
         out_record_ff <= parse.record;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_record_kind  = out_record_ff.record_kind;
   assign rsp_first_value  = out_record_ff.first_value;
   assign rsp_second_value = out_record_ff.second_value;
   assign rsp_third_value  = out_record_ff.third_value;
   assign rsp_end_of_text  = out_record_ff.end_of_text;
   assign rsp_vertex_total = out_record_ff.vertex_total;
   assign rsp_face_total   = out_record_ff.face_total;

   `OVFP_ASSERT_SAME(a_record_has_kind, clock, reset, rsp_valid && !rsp_end_of_text, rsp_record_kind != KIND_NONE)
   `OVFP_ASSERT_SAME(a_zero_byte_emits, clock, reset, advance && (in_byte_ff == CHAR_NUL), parse.emit)
   `OVFP_ASSERT_NEXT(a_emit_loads_output, clock, reset, advance && parse.emit, rsp_valid)

endmodule

// File: tb/tb_obj_vertex_face_line_parser_unit.sv
// ----------------------------------------------------------------------------
// OBJ vertex/face line parser testbench
// Streams OBJ text into the parser, one byte per request. A short list of
// hand-written lines runs first, then random vertex, face, printable, broken
// and noise lines. The request side idles and the result side stalls at random
// in several phases, and the result side holds off once for a long stretch.
// Each response is compared field by field with its table entry or a behavioral line parser kept inside the bench.
// ----------------------------------------------------------------------------
module tb_obj_vertex_face_line_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ovfp_pkg::*;

   localparam longint unsigned COORD_MAX = 64'h7FFF_FFFF;

   typedef struct {
      logic [7:0] text;
      bit         typed;
      record_type want;
   } text_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_record_kind;
   logic signed [VALUE_WIDTH-1:0] rsp_first_value;
   logic signed [VALUE_WIDTH-1:0] rsp_second_value;
   logic signed [VALUE_WIDTH-1:0] rsp_third_value;
   logic rsp_end_of_text;
   logic [TOTAL_WIDTH-1:0] rsp_vertex_total;
   logic [TOTAL_WIDTH-1:0] rsp_face_total;

   line_phase_type  line_state;
   field_phase_type field_state;
   logic [1:0]        field_idx;
   logic              minus_seen;
   longint unsigned   whole_part;
   logic [3:0]        tenths;
   logic [31:0]       first_done;
   logic [31:0]       second_done;
   logic [23:0]       vertices_seen;
   logic [23:0]       faces_seen;

   record_type   pending_records[$];
   text_row_type directed_rows[$];
   logic [7:0]   line_bytes[$];
   int unsigned  idle_pct = 0;
   int unsigned  stall_pct = 0;
   bit           hold_request = 1'b0;
   int unsigned  failures = 0;

   obj_vertex_face_line_parser_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_third_value  (rsp_third_value),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_vertex_total (rsp_vertex_total),
      .rsp_face_total   (rsp_face_total)
   );

   always #6 clock = ~clock;

   function automatic void clear_field_state();
      field_state = FP_LEAD;
      minus_seen = 1'b0;
      whole_part = 0;
      tenths = 4'd0;
   endfunction

   function automatic void restart_text();
      line_state = LP_START;
      field_idx = 2'd0;
      clear_field_state();
      first_done = 32'd0;
      second_done = 32'd0;
      vertices_seen = 24'd0;
      faces_seen = 24'd0;
   endfunction

   function automatic void add_decimal_digit(logic [7:0] c);
      longint unsigned d;
      d = c - CHAR_ZERO;
      if (whole_part > (COORD_MAX - d) / 10) whole_part = COORD_MAX;
      else whole_part = whole_part * 10 + d;
   endfunction

   function automatic logic [31:0] field_result(bit is_vertex);
      longint unsigned frac;
      longint unsigned mag;
      if (!is_vertex) return whole_part[31:0];
      frac = tenths * 10;
      if (whole_part > (COORD_MAX - frac) / 100) mag = COORD_MAX;
      else mag = whole_part * 100 + frac;
      if (minus_seen) mag = -mag;
      return mag[31:0];
   endfunction

   function automatic void close_field(bit is_vertex);
      if (field_idx == 2'd0) begin
         first_done = field_result(is_vertex);
         clear_field_state();
         field_idx = 2'd1;
      end else if (field_idx == 2'd1) begin
         second_done = field_result(is_vertex);
         clear_field_state();
         field_idx = 2'd2;
      end else begin
         field_idx = 2'd3;
      end
   endfunction

   function automatic void field_char(logic [7:0] c, bit is_vertex);
      bit digit;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (field_idx == 2'd3) return;
      case (field_state)
         FP_LEAD: begin
            if (c != CHAR_SPACE && c != CHAR_TAB) begin
               if (is_vertex && c == CHAR_MINUS) begin
                  minus_seen = 1'b1;
                  field_state = FP_INT;
               end else if (digit) begin
                  add_decimal_digit(c);
                  field_state = FP_INT;
               end else if (is_vertex && c == CHAR_DOT) begin
                  field_state = FP_FRAC1;
               end else begin
                  field_state = FP_TAIL;
               end
            end
         end
         FP_INT: begin
            if (digit) add_decimal_digit(c);
            else if (is_vertex && c == CHAR_DOT) field_state = FP_FRAC1;
            else if (c == CHAR_SPACE) close_field(is_vertex);
            else field_state = FP_TAIL;
         end
         FP_FRAC1: begin
            if (digit) begin
               tenths = 4'(c - CHAR_ZERO);
               field_state = FP_FRACR;
            end else if (c == CHAR_SPACE) begin
               close_field(is_vertex);
            end else begin
               field_state = FP_TAIL;
            end
         end
         FP_FRACR: begin
            if (!digit) begin
               if (c == CHAR_SPACE) close_field(is_vertex);
               else field_state = FP_TAIL;
            end
         end
         default: begin
            if (c == CHAR_SPACE) close_field(is_vertex);
         end
      endcase
   endfunction

   function automatic void parse_text_byte(input logic [7:0] c, output bit emit,
                                           output record_type rec);
      bit          is_vertex;
      bit          eot;
      logic [31:0] cur;
      eot = (c == CHAR_NUL);
      rec = '0;
      emit = eot;
      case (line_state)
         LP_START: begin
            if (c == CHAR_V) line_state = LP_SAW_V;
            else if (c == CHAR_F) line_state = LP_SAW_F;
            else if (c != CHAR_NEWLINE && !eot) line_state = LP_SKIP;
         end
         LP_SAW_V, LP_SAW_F: begin
            if (c == CHAR_SPACE) begin
               line_state = (line_state == LP_SAW_V) ? LP_VERTEX : LP_FACE;
               field_idx = 2'd0;
               clear_field_state();
               first_done = 32'd0;
               second_done = 32'd0;
            end else if (c == CHAR_NEWLINE) begin
               line_state = LP_START;
            end else if (!eot) begin
               line_state = LP_SKIP;
            end
         end
         LP_VERTEX, LP_FACE: begin
            is_vertex = (line_state == LP_VERTEX);
            if (c == CHAR_NEWLINE || eot) begin
               cur = field_result(is_vertex);
               rec.record_kind = is_vertex ? KIND_VERTEX : KIND_FACE;
               if (field_idx == 2'd0) begin
                  rec.first_value = cur;
               end else if (field_idx == 2'd1) begin
                  rec.first_value = first_done;
                  rec.second_value = cur;
               end else begin
                  rec.first_value = first_done;
                  rec.second_value = second_done;
                  rec.third_value = cur;
               end
               if (is_vertex) begin
                  if (vertices_seen != '1) vertices_seen = vertices_seen + 1'b1;
               end else begin
                  if (faces_seen != '1) faces_seen = faces_seen + 1'b1;
               end
               emit = 1'b1;
               line_state = LP_START;
               field_idx = 2'd0;
               clear_field_state();
            end else begin
               field_char(c, is_vertex);
            end
         end
         default: begin
            if (c == CHAR_NEWLINE) line_state = LP_START;
         end
      endcase
      if (emit) begin
         rec.end_of_text = eot;
         rec.vertex_total = vertices_seen;
         rec.face_total = faces_seen;
      end
      if (eot) restart_text();
   endfunction

   function automatic void table_text(string s);
      text_row_type row;
      row.typed = 1'b0;
      row.want = '0;
      for (int i = 0; i < s.len(); i++) begin
         row.text = s[i];
         directed_rows.push_back(row);
      end
   endfunction

   function automatic void table_typed(logic [7:0] c, logic [1:0] kind, logic [31:0] first,
                                       logic [31:0] second, logic [31:0] third, logic eot,
                                       logic [23:0] vtotal, logic [23:0] ftotal);
      text_row_type row;
      row.text = c;
      row.typed = 1'b1;
      row.want.record_kind = kind;
      row.want.first_value = first;
      row.want.second_value = second;
      row.want.third_value = third;
      row.want.end_of_text = eot;
      row.want.vertex_total = vtotal;
      row.want.face_total = ftotal;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255, 1));
      return (b == CHAR_NEWLINE) ? CHAR_TAB : b;
   endfunction

   function automatic void add_number();
      int unsigned digits;
      digits = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(3);
      if ($urandom_range(3) == 0) line_bytes.push_back(CHAR_MINUS);
      repeat (digits) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(2) == 0) begin
         line_bytes.push_back(CHAR_DOT);
         repeat ($urandom_range(3)) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(7) == 0) line_bytes.push_back(junk_byte());
   endfunction

   function automatic void build_line();
      int unsigned pick;
      int unsigned fields;
      line_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 70) begin
         line_bytes.push_back((pick < 40) ? CHAR_V : CHAR_F);
         line_bytes.push_back(CHAR_SPACE);
         fields = $urandom_range(4);
         for (int i = 0; i < fields; i++) begin
            if (i != 0) line_bytes.push_back(CHAR_SPACE);
            if ($urandom_range(4) == 0) begin
               line_bytes.push_back($urandom_range(1) ? CHAR_TAB : CHAR_SPACE);
            end
            add_number();
         end
      end else if (pick < 80) begin
         repeat ($urandom_range(10, 1)) line_bytes.push_back(8'($urandom_range(126, 32)));
      end else if (pick < 88) begin
         line_bytes.push_back($urandom_range(1) ? CHAR_V : CHAR_F);
         if ($urandom_range(1)) line_bytes.push_back(junk_byte());
      end else if (pick < 96) begin
         repeat ($urandom_range(8, 1)) line_bytes.push_back(8'($urandom_range(255, 1)));
      end
      line_bytes.push_back(($urandom_range(15) == 0) ? CHAR_NUL : CHAR_NEWLINE);
   endfunction

   task automatic offer_byte(input logic [7:0] c, input bit typed, input record_type want);
      bit         taken;
      bit         emit;
      record_type rec;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= c;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if (!req_stall) begin
            taken = 1'b1;
            parse_text_byte(c, emit, rec);
            if (typed) pending_records.push_back(want);
            else if (emit) pending_records.push_back(rec);
         end
         @(posedge clock);
      end
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function automatic void take_response();
      record_type want;
      if (pending_records.size() == 0) begin
         failures++;
         $display("%0t: response with no request pending, expected none, actual kind %0d",
                  $time, rsp_record_kind);
      end else begin
         want = pending_records.pop_front();
         compare_field("record_kind", want.record_kind, rsp_record_kind);
         compare_field("first_value", want.first_value, rsp_first_value);
         compare_field("second_value", want.second_value, rsp_second_value);
         compare_field("third_value", want.third_value, rsp_third_value);
         compare_field("end_of_text", want.end_of_text, rsp_end_of_text);
         compare_field("vertex_total", want.vertex_total, rsp_vertex_total);
         compare_field("face_total", want.face_total, rsp_face_total);
      end
   endfunction

   initial begin
      int unsigned hold_count;
      bit          hold_used;
      hold_count = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_count = 90;
         end
         if (hold_count != 0) begin
            rsp_stall <= 1'b1;
            hold_count--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) take_response();
      end
   end

   initial begin
      int unsigned phase_bytes;
      restart_text();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      table_typed(CHAR_NUL, KIND_NONE, 32'd0, 32'd0, 32'd0, 1'b1, 24'd0, 24'd0);
      table_text("f 7\t9 -3\n");
      table_text("v -22222222");
      table_typed(CHAR_NEWLINE, KIND_VERTEX, 32'h8000_0001, 32'd0, 32'd0, 1'b0, 24'd1, 24'd1);
      table_text("v\n");
      table_typed(CHAR_NUL, KIND_NONE, 32'd0, 32'd0, 32'd0, 1'b1, 24'd1, 24'd1);
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].text, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 61; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 61; end
            3: begin idle_pct = 12; stall_pct = 12; end
            default: begin
               idle_pct = 0;
               stall_pct = 25;
               hold_request = 1'b1;
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 285) begin
            build_line();
            foreach (line_bytes[i]) offer_byte(line_bytes[i], 1'b0, '0);
            phase_bytes += line_bytes.size();
         end
      end
      req_valid <= 1'b0;

      while (pending_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
